>>> rtl/lbpd_pkg.sv
`timescale 1ns / 1ps
// Package for the locked block pair dispatcher.
// Holds command, reply and configuration index codes, fixed sizes and the column range type.
package lbpd_pkg;

    localparam int MAX_BLOCKS  = 32;
    localparam int MAX_WORKERS = 16;

    localparam int BLK_W    = 5;
    localparam int NBLK_W   = 6;
    localparam int WORKER_W = 4;
    localparam int COUNT_W  = 4;
    localparam int MOS_W    = 13;
    localparam int COL_W    = 16;
    localparam int PAIR_W   = 2 * BLK_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        CMD_REQUEST_JOB  = 2'd0,
        CMD_SEND_RESULTS = 2'd1,
        CMD_START_SWEEP  = 2'd2,
        CMD_INVALID      = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        REPLY_FINISHED = 3'd0,
        REPLY_ASSIGNED = 3'd1,
        REPLY_WAIT     = 3'd2,
        REPLY_TAKEN    = 3'd3,
        REPLY_STARTED  = 3'd4,
        REPLY_NO_JOB   = 3'd5,
        REPLY_BAD      = 3'd6
    } reply_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_NUM_BLOCKS    = 3'd0,
        CFG_NUM_WORKERS   = 3'd1,
        CFG_MOS_PER_BLOCK = 3'd2,
        CFG_FIRST_ORBITAL = 3'd3,
        CFG_LAST_ORBITAL  = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [COL_W-1:0] col_start;
        logic [COL_W-1:0] col_last;
    } col_range_t;

endpackage

>>> rtl/lbpd_col_range.sv
`timescale 1ns / 1ps
// Column range of one orbital block: start saturated, end clamped.
// Depends on lbpd_pkg.
module lbpd_col_range (
    input  logic [lbpd_pkg::BLK_W-1:0] blk,
    input  logic [lbpd_pkg::MOS_W-1:0] mos_per_block,
    input  logic [lbpd_pkg::COL_W-1:0] first_orbital,
    input  logic [lbpd_pkg::COL_W-1:0] last_orbital,
    output lbpd_pkg::col_range_t       range
);
    import lbpd_pkg::*;

    localparam int PROD_W = BLK_W + MOS_W;
    localparam int SUM_W  = PROD_W + 1;

    logic [MOS_W-1:0]  mos_eff;
    logic [PROD_W-1:0] prod;
    logic [SUM_W-1:0]  start_full;
    logic [SUM_W-1:0]  last_full;

    assign mos_eff    = (mos_per_block == '0) ? MOS_W'(1) : mos_per_block;
    assign prod       = PROD_W'(blk) * PROD_W'(mos_eff);
    assign start_full = SUM_W'(prod) + SUM_W'(first_orbital);
    assign last_full  = SUM_W'(prod) + SUM_W'(mos_eff) - SUM_W'(1);

    always_comb
    begin
        if (start_full[SUM_W-1:COL_W] != '0)
        begin
            range.col_start = '1;
        end
        else
        begin
            range.col_start = start_full[COL_W-1:0];
        end
        if (last_full < SUM_W'(last_orbital))
        begin
            range.col_last = last_full[COL_W-1:0];
        end
        else
        begin
            range.col_last = last_orbital;
        end
    end

endmodule

>>> rtl/locked_block_pair_dispatcher.sv
`timescale 1ns / 1ps
// Locked block pair dispatcher: top level.
// Depends on lbpd_pkg and lbpd_col_range.
//
// Usage:
//   Command channel in_valid/in_stall carries cmd and worker. A command is
//   taken when in_valid is high and in_stall low. Every command produces
//   exactly one reply on out_valid/out_stall, in order.
//   Configuration channel cfg_valid/cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no command is in flight.
//   A reply is registered: the command passes one input register, then the
//   lookup, cursor step and two column multiplies, then the reply register.
//   One command per cycle is sustained while out_stall is low.
//   When out_stall is held with a reply waiting, the command register stalls
//   the input side; no reply is lost or repeated.
//   Reset leaves the sweep state as a start command would, clears all job
//   records and loads the default configuration: 4 blocks, 1 worker,
//   1 column per block, orbital range 0 to 0.
module locked_block_pair_dispatcher (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic [1:0]                     cmd,
    input  logic [lbpd_pkg::WORKER_W-1:0]  worker,
    output logic                           out_valid,
    input  logic                           out_stall,
    output lbpd_pkg::reply_t               reply,
    output logic [lbpd_pkg::BLK_W-1:0]     block_first,
    output logic [lbpd_pkg::BLK_W-1:0]     block_second,
    output logic [lbpd_pkg::COL_W-1:0]     first_col_start,
    output logic [lbpd_pkg::COL_W-1:0]     first_col_end,
    output logic [lbpd_pkg::COL_W-1:0]     second_col_start,
    output logic [lbpd_pkg::COL_W-1:0]     second_col_end,
    output logic                           sweep_done,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [lbpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [lbpd_pkg::CFG_DATA_W-1:0] cfg_data
);
    import lbpd_pkg::*;

    localparam int SUM_W = NBLK_W + 1;

    // configuration
    logic [NBLK_W-1:0]  num_blocks_reg;
    logic [COUNT_W-1:0] num_workers_reg;
    logic [MOS_W-1:0]   mos_per_block_reg;
    logic [COL_W-1:0]   first_orbital_reg;
    logic [COL_W-1:0]   last_orbital_reg;

    // input register
    logic                in_valid_reg;
    cmd_t                cmd_reg;
    logic [WORKER_W-1:0] worker_reg;

    // sweep state
    logic [NBLK_W-1:0]     diag_reg, diag_next;
    logic [BLK_W-1:0]      idx_reg, idx_next;
    logic [MAX_BLOCKS-1:0] lock_reg, lock_next;
    logic                  resv_valid_reg, resv_valid_next;
    logic [PAIR_W-1:0]     resv_pair_reg, resv_pair_next;
    logic [COUNT_W-1:0]    fin_count_reg, fin_count_next;
    logic [MAX_WORKERS-1:0] job_valid_reg, job_valid_next;
    logic [PAIR_W-1:0]     job_pair_reg [MAX_WORKERS];
    logic                  job_write;

    // reply register
    logic        out_valid_reg;
    reply_t      reply_reg, reply_next;
    logic [BLK_W-1:0] blk_a_reg, blk_b_reg, blk_a_next, blk_b_next;
    col_range_t  range_a_reg, range_b_reg, range_a_next, range_b_next;
    logic        done_reg;

    logic        out_ready;
    logic        fire;
    logic        good_worker;

    // cursor step
    logic [NBLK_W-1:0] nb_eff;
    logic [SUM_W-1:0]  sum0;
    logic              skip;
    logic [NBLK_W-1:0] diag1;
    logic [BLK_W-1:0]  idx1;
    logic              have_cur;
    logic [SUM_W-1:0]  pb_cur;

    logic [BLK_W-1:0]  pa, pb;
    logic              have;
    logic [PAIR_W-1:0] rec_pair;
    col_range_t        range_a, range_b;

    assign cfg_ready = 1'b1;
    assign out_ready = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && out_ready;
    assign in_stall  = in_valid_reg && !out_ready;
    assign good_worker = (worker_reg != '0) && (32'(worker_reg) < MAX_WORKERS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_blocks_reg    <= NBLK_W'(4);
            num_workers_reg   <= COUNT_W'(1);
            mos_per_block_reg <= MOS_W'(1);
            first_orbital_reg <= '0;
            last_orbital_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_NUM_BLOCKS:    num_blocks_reg    <= cfg_data[NBLK_W-1:0];
                CFG_NUM_WORKERS:   num_workers_reg   <= cfg_data[COUNT_W-1:0];
                CFG_MOS_PER_BLOCK: mos_per_block_reg <= cfg_data[MOS_W-1:0];
                CFG_FIRST_ORBITAL: first_orbital_reg <= cfg_data[COL_W-1:0];
                CFG_LAST_ORBITAL:  last_orbital_reg  <= cfg_data[COL_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_reg    <= CMD_INVALID;
            worker_reg <= '0;
        end
        else if (!in_stall && in_valid)
        begin
            cmd_reg    <= cmd_t'(cmd);
            worker_reg <= worker;
        end
    end

    // next pair from the cursor, or the held reservation
    always_comb
    begin
        nb_eff   = (num_blocks_reg > NBLK_W'(MAX_BLOCKS)) ? NBLK_W'(MAX_BLOCKS)
                                                           : num_blocks_reg;
        sum0     = SUM_W'(idx_reg) + SUM_W'(diag_reg);
        skip     = sum0 >= SUM_W'(nb_eff);
        diag1    = skip ? diag_reg + NBLK_W'(1) : diag_reg;
        idx1     = skip ? '0 : idx_reg;
        have_cur = (diag_reg < nb_eff) && (diag1 < nb_eff);
        pb_cur   = SUM_W'(idx1) + SUM_W'(diag1);

        if (resv_valid_reg)
        begin
            pa   = resv_pair_reg[PAIR_W-1:BLK_W];
            pb   = resv_pair_reg[BLK_W-1:0];
            have = 1'b1;
        end
        else
        begin
            pa   = idx1;
            pb   = pb_cur[BLK_W-1:0];
            have = have_cur;
        end
    end

    lbpd_col_range u_range_a (
        .blk           (pa),
        .mos_per_block (mos_per_block_reg),
        .first_orbital (first_orbital_reg),
        .last_orbital  (last_orbital_reg),
        .range         (range_a)
    );

    lbpd_col_range u_range_b (
        .blk           (pb),
        .mos_per_block (mos_per_block_reg),
        .first_orbital (first_orbital_reg),
        .last_orbital  (last_orbital_reg),
        .range         (range_b)
    );

    always_comb
    begin
        diag_next       = diag_reg;
        idx_next        = idx_reg;
        lock_next       = lock_reg;
        resv_valid_next = resv_valid_reg;
        resv_pair_next  = resv_pair_reg;
        fin_count_next  = fin_count_reg;
        job_valid_next  = job_valid_reg;
        job_write       = 1'b0;
        reply_next      = REPLY_BAD;
        blk_a_next      = '0;
        blk_b_next      = '0;
        range_a_next    = '0;
        range_b_next    = '0;
        rec_pair        = job_pair_reg[worker_reg];

        unique case (cmd_reg)
            CMD_START_SWEEP:
            begin
                diag_next       = '0;
                idx_next        = '0;
                lock_next       = '0;
                resv_valid_next = 1'b0;
                resv_pair_next  = '0;
                fin_count_next  = '0;
                reply_next      = REPLY_STARTED;
            end
            CMD_REQUEST_JOB:
            begin
                if (good_worker)
                begin
                    if (!resv_valid_reg && (diag_reg < nb_eff))
                    begin
                        if (!have_cur)
                        begin
                            diag_next = diag1;
                            idx_next  = '0;
                        end
                        else if ((pb_cur + SUM_W'(1)) < SUM_W'(nb_eff))
                        begin
                            diag_next = diag1;
                            idx_next  = idx1 + BLK_W'(1);
                        end
                        else
                        begin
                            diag_next = diag1 + NBLK_W'(1);
                            idx_next  = '0;
                        end
                    end
                    if (!have)
                    begin
                        reply_next = REPLY_FINISHED;
                        if (fin_count_reg != '1)
                        begin
                            fin_count_next = fin_count_reg + COUNT_W'(1);
                        end
                    end
                    else if (!lock_reg[pa] && !lock_reg[pb])
                    begin
                        lock_next[pa]  = 1'b1;
                        lock_next[pb]  = 1'b1;
                        job_valid_next[worker_reg] = 1'b1;
                        job_write       = 1'b1;
                        resv_valid_next = 1'b0;
                        reply_next      = REPLY_ASSIGNED;
                        blk_a_next      = pa;
                        blk_b_next      = pb;
                        range_a_next    = range_a;
                        range_b_next    = range_b;
                    end
                    else
                    begin
                        resv_valid_next = 1'b1;
                        resv_pair_next  = {pa, pb};
                        reply_next      = REPLY_WAIT;
                    end
                end
            end
            CMD_SEND_RESULTS:
            begin
                if (good_worker)
                begin
                    if (job_valid_reg[worker_reg])
                    begin
                        lock_next[rec_pair[PAIR_W-1:BLK_W]] = 1'b0;
                        lock_next[rec_pair[BLK_W-1:0]]      = 1'b0;
                        job_valid_next[worker_reg] = 1'b0;
                        reply_next = REPLY_TAKEN;
                    end
                    else
                    begin
                        reply_next = REPLY_NO_JOB;
                    end
                end
            end
            CMD_INVALID:
            begin
                reply_next = REPLY_BAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diag_reg       <= '0;
            idx_reg        <= '0;
            lock_reg       <= '0;
            resv_valid_reg <= 1'b0;
            resv_pair_reg  <= '0;
            fin_count_reg  <= '0;
            job_valid_reg  <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (fire)
            begin
                diag_reg       <= diag_next;
                idx_reg        <= idx_next;
                lock_reg       <= lock_next;
                resv_valid_reg <= resv_valid_next;
                resv_pair_reg  <= resv_pair_next;
                fin_count_reg  <= fin_count_next;
                job_valid_reg  <= job_valid_next;
            end
            if (out_ready)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && job_write)
        begin
            job_pair_reg[worker_reg] <= {pa, pb};
        end
        if (fire)
        begin
            reply_reg   <= reply_next;
            blk_a_reg   <= blk_a_next;
            blk_b_reg   <= blk_b_next;
            range_a_reg <= range_a_next;
            range_b_reg <= range_b_next;
            done_reg    <= fin_count_next >= num_workers_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign reply            = reply_reg;
    assign block_first      = blk_a_reg;
    assign block_second     = blk_b_reg;
    assign first_col_start  = range_a_reg.col_start;
    assign first_col_end    = range_a_reg.col_last;
    assign second_col_start = range_b_reg.col_start;
    assign second_col_end   = range_b_reg.col_last;
    assign sweep_done       = done_reg;

    // the cursor never runs past the block limit
    a_diag_bound: assert property (@(posedge clk) disable iff (!rst_n)
        diag_reg <= NBLK_W'(MAX_BLOCKS))
        else $error("cursor diagonal beyond block limit");

    // pair fields only carry data on an assignment
    a_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reply != REPLY_ASSIGNED) |->
        (block_first == '0 && block_second == '0 &&
         first_col_start == '0 && second_col_start == '0))
        else $error("pair fields set on non-assigned reply");

    // pairs are handed out lower block first
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && reply == REPLY_ASSIGNED) |-> (block_first <= block_second))
        else $error("assigned pair out of order");

    // an assignment leaves both blocks locked
    a_lock_set: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && reply_next == REPLY_ASSIGNED) |=>
        (lock_reg[$past(pa)] && lock_reg[$past(pb)]))
        else $error("assigned blocks not locked");

endmodule
